// File: rtl/twd_pkg.sv
// Package for the task worker dispatch block.
// Shared constants, register codes and controller/datapath structs.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package twd_pkg;

  localparam int MAX_WORKERS = 16;
  localparam int WIDX_W      = $clog2(MAX_WORKERS);  // worker index width
  localparam int CNT_W       = 5;                    // worker_count register width
  localparam int TAG_W       = 16;
  localparam int SEED_W      = 48;
  localparam int CFG_IDX_W   = 2;

  localparam logic [SEED_W-1:0] SEED_RESET = 48'h1234ABCD330E;
  localparam logic [34:0]       LCG_MUL    = 35'h5DEECE66D;
  localparam logic [SEED_W-1:0] LCG_ADD    = 48'hB;

  // one 16-bit slice of the generator state per multiply step
  localparam int MUL_STEPS = 3;
  // 32-bit draw word reduced one nibble per step
  localparam int MOD_STEPS = 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WORKER_COUNT = 2'd0,
    CFG_DUAL_DISPATCH = 2'd1,
    CFG_ROUND_ROBIN = 2'd2,
    CFG_RANDOM_SEED = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic       start;      // input transaction taken, latch tag, fixed picks
    logic       mul_en;     // generator multiply step
    logic       mod_en;     // remainder step
    logic [2:0] step;
    logic       store_k;    // first draw result -> first pick
    logic       store_j;    // second draw result -> second pick
    logic       load_out;   // picks -> output buffer
    logic       out_phase;  // 0: first result, 1: second result
  } twd_cmd_t;

  typedef struct packed {
    logic n_one;
    logic n_two;
    logic dual;
    logic rr;
    logic rem_eq_k;
    logic ob_two;
  } twd_status_t;

endpackage

`default_nettype wire

// File: rtl/task_worker_dispatch_core.sv
// Top level of the task worker dispatch block.
// Instantiates twd_ctrl and twd_dp; depends on twd_pkg.
//
// Usage:
//  - Input channel (in_valid / in_stall / task_tag): one transaction is one
//    task. in_stall is high while a task is being worked on.
//  - Output channel (out_valid / out_stall / worker_index, task_handle,
//    copy_count, last_of_task): one or two transactions per task, the
//    second (dual dispatch) marked by last_of_task.
//  - Config port (cfg_write / cfg_index / cfg_data): single-cycle writes,
//    only while no task is in flight. Writing worker_count clears the round
//    robin index; writing random_seed reloads the generator.
// Sequencing:
//  - Fixed routes and round robin: the task goes straight from idle to the
//    done state, which loads the picks into the output buffer.
//  - Random: each draw is a run of multiply steps (shared 16x35 multiplier)
//    plus remainder steps (one nibble per cycle) plus a check step; single
//    mode makes one draw, dual mode two or more (a second pick equal to the
//    first is drawn again).
//  - Either way the block takes no new task until the current one has been
//    loaded into the output buffer.
// Reset (rst, synchronous) restores the register defaults, clears the
// round robin index and loads the default seed; no outputs are valid.
// Stalling: a finished task sits in the output buffer while the next task is
// computed; once both are full the input stalls until out_stall drops.
`timescale 1ns / 1ps
`default_nettype none

module task_worker_dispatch_core
  import twd_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  // config
  input  wire logic                 cfg_write,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [SEED_W-1:0]    cfg_data,
  // input tasks
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [TAG_W-1:0]     task_tag,
  // dispatch results
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [WIDX_W-1:0]         worker_index,
  output logic [TAG_W-1:0]          task_handle,
  output logic [1:0]                copy_count,
  output logic                      last_of_task
);

  twd_cmd_t    cmd;
  twd_status_t st;

  // sequencing: draw steps, pick checks, output buffer drain
  twd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .st        (st),
    .cmd       (cmd)
  );

  // config registers, LCG, modulo unit, picks and result payload
  twd_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .task_tag     (task_tag),
    .cmd          (cmd),
    .st           (st),
    .worker_index (worker_index),
    .task_handle  (task_handle),
    .copy_count   (copy_count),
    .last_of_task (last_of_task)
  );

endmodule

`default_nettype wire

// File: rtl/twd_dp.sv
// Datapath of the task worker dispatch block: config registers, round robin
// index, 48-bit LCG with a shared 16x35 multiplier, nibble-serial modulo unit,
// pick registers and output buffer. Depends on twd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module twd_dp
  import twd_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_write,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [SEED_W-1:0]    cfg_data,
  input  wire logic [TAG_W-1:0]     task_tag,
  input  wire twd_cmd_t             cmd,
  output twd_status_t               st,
  output logic [WIDX_W-1:0]         worker_index,
  output logic [TAG_W-1:0]          task_handle,
  output logic [1:0]                copy_count,
  output logic                      last_of_task
);

  logic [CNT_W-1:0]  worker_count;
  logic              dual_dispatch;
  logic              round_robin_mode;
  logic [WIDX_W-1:0] rr_index;
  logic [SEED_W-1:0] rng_state;
  logic [SEED_W-1:0] acc;
  logic [WIDX_W-1:0] rem;
  logic [WIDX_W-1:0] pick_k, pick_j;
  logic [TAG_W-1:0]  tag;
  logic              two;
  logic [WIDX_W-1:0] ob_k, ob_j;
  logic [TAG_W-1:0]  ob_tag;
  logic              ob_two;

  logic [CNT_W-1:0]  n_eff;
  logic [CNT_W-1:0]  rr_p1, j_rr, j_p1, rr_next_dual;
  logic [15:0]       chunk;
  logic [50:0]       prod;
  logic [SEED_W-1:0] prod_sh, mul_sum;
  logic [31:0]       draw_word;
  logic [3:0]        nibble;
  logic [WIDX_W-1:0] rem_in, rem_next;

  // one remainder digit: four restoring steps against a count of at most 16
  function automatic logic [WIDX_W-1:0] mod_nibble(input logic [WIDX_W-1:0] r_in,
                                                   input logic [3:0] bits,
                                                   input logic [CNT_W-1:0] n);
    logic [WIDX_W-1:0] r;
    logic [CNT_W-1:0]  t;
    r = r_in;
    for (int i = 3; i >= 0; i--) begin
      t = {r, bits[i]};
      if (t >= n) begin
        t = t - n;
      end
      r = t[WIDX_W-1:0];
    end
    return r;
  endfunction

  always_comb begin
    if (worker_count == '0) begin
      n_eff = CNT_W'(1);
    end else if (worker_count > CNT_W'(MAX_WORKERS)) begin
      n_eff = CNT_W'(MAX_WORKERS);
    end else begin
      n_eff = worker_count;
    end
  end

  // round robin picks; rr_index always stays below n_eff
  always_comb begin
    rr_p1        = {1'b0, rr_index} + CNT_W'(1);
    j_rr         = (rr_p1 == n_eff) ? '0 : rr_p1;
    j_p1         = j_rr + CNT_W'(1);
    rr_next_dual = (j_p1 == n_eff) ? '0 : j_p1;
  end

  // LCG step: x*A + C mod 2^48, x taken as three 16-bit slices, C added on the last
  always_comb begin
    chunk = rng_state[{cmd.step[1:0], 4'b0000} +: 16];
    prod  = 51'(chunk) * 51'(LCG_MUL);
    case (cmd.step[1:0])
      2'd0:    prod_sh = prod[47:0];
      2'd1:    prod_sh = {prod[31:0], 16'b0};
      2'd2:    prod_sh = {prod[15:0], 32'b0};
      default: prod_sh = '0;
    endcase
    mul_sum = ((cmd.step == 3'd0) ? '0 : acc) + prod_sh
              + ((cmd.step == 3'(MUL_STEPS - 1)) ? LCG_ADD : '0);
  end

  always_comb begin
    draw_word = {1'b0, rng_state[47:17]};
    nibble    = draw_word[{~cmd.step, 2'b00} +: 4];
    rem_in    = (cmd.step == 3'd0) ? '0 : rem;
    rem_next  = mod_nibble(rem_in, nibble, n_eff);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      worker_count     <= CNT_W'(1);
      dual_dispatch    <= 1'b0;
      round_robin_mode <= 1'b0;
      rr_index         <= '0;
      rng_state        <= SEED_RESET;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          CFG_WORKER_COUNT: begin
            worker_count <= cfg_data[CNT_W-1:0];
            rr_index     <= '0;
          end
          CFG_DUAL_DISPATCH: dual_dispatch <= cfg_data[0];
          CFG_ROUND_ROBIN:   round_robin_mode <= cfg_data[0];
          CFG_RANDOM_SEED:   rng_state <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.start && n_eff != CNT_W'(1) && round_robin_mode &&
          !(dual_dispatch && n_eff == CNT_W'(2))) begin
        rr_index <= dual_dispatch ? rr_next_dual[WIDX_W-1:0] : j_rr[WIDX_W-1:0];
      end
      if (cmd.mul_en && cmd.step == 3'(MUL_STEPS - 1)) begin
        rng_state <= mul_sum;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      acc <= mul_sum;
    end
    if (cmd.mod_en) begin
      rem <= rem_next;
    end
    if (cmd.start) begin
      tag <= task_tag;
      if (n_eff == CNT_W'(1)) begin
        pick_k <= '0;
        two    <= 1'b0;
      end else if (dual_dispatch && n_eff == CNT_W'(2)) begin
        pick_k <= WIDX_W'(0);
        pick_j <= WIDX_W'(1);
        two    <= 1'b1;
      end else begin
        two <= dual_dispatch;
        if (round_robin_mode) begin
          pick_k <= rr_index;
          pick_j <= j_rr[WIDX_W-1:0];
        end
      end
    end
    if (cmd.store_k) begin
      pick_k <= rem;
    end
    if (cmd.store_j) begin
      pick_j <= rem;
    end
    if (cmd.load_out) begin
      ob_k   <= pick_k;
      ob_j   <= pick_j;
      ob_tag <= tag;
      ob_two <= two;
    end
  end

  always_comb begin
    st.n_one    = (n_eff == CNT_W'(1));
    st.n_two    = (n_eff == CNT_W'(2));
    st.dual     = dual_dispatch;
    st.rr       = round_robin_mode;
    st.rem_eq_k = (rem == pick_k);
    st.ob_two   = ob_two;
  end

  assign worker_index = cmd.out_phase ? ob_j : ob_k;
  assign task_handle  = ob_tag;
  assign copy_count   = ob_two ? 2'd2 : 2'd1;
  assign last_of_task = ob_two ? cmd.out_phase : 1'b1;

endmodule

`default_nettype wire

// File: rtl/twd_ctrl.sv
// Controller of the task worker dispatch block: sequences the draw steps
// and drains the two-entry output buffer. Depends on twd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module twd_ctrl
  import twd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  output logic             out_valid,
  input  wire logic        out_stall,
  input  wire twd_status_t st,
  output twd_cmd_t         cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_MOD,
    S_CHECK,
    S_DONE
  } state_t;

  state_t     state;
  logic [2:0] step;
  logic       first_draw;
  logic       ob_full;
  logic       ob_phase;

  always_comb begin
    cmd.start     = (state == S_IDLE) && in_valid;
    cmd.mul_en    = (state == S_MUL);
    cmd.mod_en    = (state == S_MOD);
    cmd.step      = step;
    cmd.store_k   = (state == S_CHECK) && first_draw;
    cmd.store_j   = (state == S_CHECK) && !first_draw && !st.rem_eq_k;
    cmd.load_out  = (state == S_DONE) && !ob_full;
    cmd.out_phase = ob_phase;
  end

  assign in_stall  = (state != S_IDLE);
  assign out_valid = ob_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      step       <= '0;
      first_draw <= 1'b0;
      ob_full    <= 1'b0;
      ob_phase   <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            step       <= '0;
            first_draw <= 1'b1;
            if (st.n_one || st.rr || (st.dual && st.n_two)) begin
              state <= S_DONE;
            end else begin
              state <= S_MUL;
            end
          end
        end
        S_MUL: begin
          if (step == 3'(MUL_STEPS - 1)) begin
            step  <= '0;
            state <= S_MOD;
          end else begin
            step <= step + 3'd1;
          end
        end
        S_MOD: begin
          if (step == 3'(MOD_STEPS - 1)) begin
            step  <= '0;
            state <= S_CHECK;
          end else begin
            step <= step + 3'd1;
          end
        end
        S_CHECK: begin
          if (first_draw) begin
            first_draw <= 1'b0;
            state      <= st.dual ? S_MUL : S_DONE;
          end else begin
            state <= st.rem_eq_k ? S_MUL : S_DONE;  // redraw on collision
          end
        end
        S_DONE: begin
          if (!ob_full) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase

      if (cmd.load_out) begin
        ob_full  <= 1'b1;
        ob_phase <= 1'b0;
      end else if (ob_full && !out_stall) begin
        if (!ob_phase && st.ob_two) begin
          ob_phase <= 1'b1;
        end else begin
          ob_full  <= 1'b0;
          ob_phase <= 1'b0;
        end
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/twd_checker.sv
// Port-level checks for task_worker_dispatch_core, attached by bind.
// Depends on twd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module twd_checker
  import twd_pkg::*;
(
  input wire logic                 clk,
  input wire logic                 rst,
  input wire logic                 in_stall,
  input wire logic                 out_valid,
  input wire logic                 out_stall,
  input wire logic [WIDX_W-1:0]    worker_index,
  input wire logic [TAG_W-1:0]     task_handle,
  input wire logic [1:0]           copy_count,
  input wire logic                 last_of_task
);

  // nothing pending right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid && !in_stall)
    else $error("output valid or input stalled after reset");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(worker_index) &&
                               $stable(task_handle) && $stable(last_of_task))
    else $error("stalled result changed");

  // single-copy transactions are always the last of their task
  a_single_last: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (copy_count == 2'd1 && last_of_task) || copy_count == 2'd2)
    else $error("bad copy count / last flag");

  // first of a dual dispatch is followed at once by its last, same task
  a_dual_pair: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && copy_count == 2'd2 && !last_of_task
    |=> out_valid && last_of_task && copy_count == 2'd2 && $stable(task_handle)
        && worker_index != $past(worker_index))
    else $error("dual dispatch pair broken");

endmodule

bind task_worker_dispatch_core twd_checker u_twd_checker (.*);

`default_nettype wire

// File: bench/tb_task_worker_dispatch_core.sv
// Self-checking testbench for task_worker_dispatch_core.
// Predicts each dispatch from a local model and checks every output transaction.
// Depends on twd_pkg and the RTL under rtl/.
`timescale 1ns / 1ps

module tb_task_worker_dispatch_core;
  import twd_pkg::*;

  localparam int CLK_HALF     = 4;
  localparam int RESET_CYCLES = 9;
  localparam int IDLE_LIMIT   = 4000;   // cycles with no transaction on either side
  localparam int RANDOM_TASKS = 900;
  localparam int MAX_REPORTS  = 10;
  localparam int SETTLE       = 20;     // quiet cycles before the verdict

  // 48-bit LCG, same constants as the classic rand48 family
  localparam logic [SEED_W-1:0] LCG_MULT     = 48'h5DEECE66D;
  localparam logic [SEED_W-1:0] LCG_INC      = 48'hB;
  localparam logic [SEED_W-1:0] DEFAULT_SEED = 48'h1234ABCD330E;

  // ---------------------------------------------------------------------------
  // DUT connections, all inputs known from time zero
  // ---------------------------------------------------------------------------
  logic              clk       = 1'b0;
  logic              rst       = 1'b1;
  logic              cfg_write = 1'b0;
  cfg_reg_t          cfg_index = CFG_WORKER_COUNT;
  logic [SEED_W-1:0] cfg_data  = '0;
  logic              in_valid  = 1'b0;
  logic              in_stall;
  logic [TAG_W-1:0]  task_tag  = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [WIDX_W-1:0] worker_index;
  logic [TAG_W-1:0]  task_handle;
  logic [1:0]        copy_count;
  logic              last_of_task;

  task_worker_dispatch_core dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .task_tag     (task_tag),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .worker_index (worker_index),
    .task_handle  (task_handle),
    .copy_count   (copy_count),
    .last_of_task (last_of_task)
  );

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Dispatch model: own copy of the registers, the round robin pointer and
  // the generator state. Results are queued in the order the DUT must send.
  // ---------------------------------------------------------------------------
  typedef struct packed {
    logic [WIDX_W-1:0] worker;
    logic [TAG_W-1:0]  handle;
    logic [1:0]        copies;
    logic              last;
  } dispatch_t;

  dispatch_t         pending_dispatch[$];
  logic [4:0]        mdl_count;
  logic              mdl_dual;
  logic              mdl_rr;
  logic [SEED_W-1:0] mdl_lcg;
  logic [WIDX_W-1:0] mdl_rr_idx;

  int  error_count = 0;
  bit  send_quiet  = 1'b0;   // no gaps between input transactions
  bit  drain_quiet = 1'b0;   // no output stalls
  int  stall_left  = 0;
  int  idle_cycles = 0;

  // a count of zero acts as one, anything above the worker limit saturates
  function automatic int unsigned live_workers();
    if (mdl_count == 0)
      return 1;
    else if (mdl_count > MAX_WORKERS)
      return MAX_WORKERS;
    else
      return mdl_count;
  endfunction

  // advance the generator, take bits 47..17 modulo the worker count
  function automatic int unsigned lcg_pick(int unsigned n);
    mdl_lcg = mdl_lcg * LCG_MULT + LCG_INC;
    return (mdl_lcg >> 17) % n;
  endfunction

  function automatic void queue_result(int unsigned w, logic [TAG_W-1:0] tag,
                                       logic [1:0] copies, logic last);
    dispatch_t r;
    r.worker = WIDX_W'(w);
    r.handle = tag;
    r.copies = copies;
    r.last   = last;
    pending_dispatch.push_back(r);
  endfunction

  function automatic void route_task(logic [TAG_W-1:0] tag);
    int unsigned n, k, j;
    n = live_workers();
    if (n == 1) begin
      // single worker: fixed route, dual mode ignored, no state change
      queue_result(0, tag, 2'd1, 1'b1);
    end else if (mdl_dual) begin
      if (n == 2) begin
        k = 0;
        j = 1;
      end else if (mdl_rr) begin
        k = mdl_rr_idx % n;
        j = (k + 1) % n;
        mdl_rr_idx = WIDX_W'((j + 1) % n);
      end else begin
        // second pick redrawn until it differs from the first
        k = lcg_pick(n);
        do
          j = lcg_pick(n);
        while (j == k);
      end
      queue_result(k, tag, 2'd2, 1'b0);
      queue_result(j, tag, 2'd2, 1'b1);
    end else begin
      if (mdl_rr) begin
        k = mdl_rr_idx % n;
        mdl_rr_idx = WIDX_W'((k + 1) % n);
      end else begin
        k = lcg_pick(n);
      end
      queue_result(k, tag, 2'd1, 1'b1);
    end
  endfunction

  function automatic void apply_cfg(cfg_reg_t idx, logic [SEED_W-1:0] value);
    case (idx)
      CFG_WORKER_COUNT: begin
        mdl_count  = value[4:0];
        mdl_rr_idx = '0;
      end
      CFG_DUAL_DISPATCH: mdl_dual = value[0];
      CFG_ROUND_ROBIN:   mdl_rr   = value[0];
      CFG_RANDOM_SEED:   mdl_lcg  = value;
      default: ;
    endcase
  endfunction

  function automatic void note_error(string msg);
    if (error_count < MAX_REPORTS)
      $display("%0t ERROR: %s", $time, msg);
    error_count++;
  endfunction

  function automatic void check_result();
    dispatch_t want;
    if (pending_dispatch.size() == 0) begin
      note_error($sformatf("unexpected result w=%0d h=%h c=%0d l=%0d",
                           worker_index, task_handle, copy_count, last_of_task));
    end else begin
      want = pending_dispatch.pop_front();
      if (worker_index !== want.worker || task_handle !== want.handle ||
          copy_count !== want.copies || last_of_task !== want.last)
        note_error($sformatf("exp w=%0d h=%h c=%0d l=%0d, got w=%0d h=%h c=%0d l=%0d",
                             want.worker, want.handle, want.copies, want.last,
                             worker_index, task_handle, copy_count, last_of_task));
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Monitor: everything sampled at the rising edge, before the NBA updates.
  // Output is checked first, then config writes and input transactions feed
  // the model. A result can never come in the cycle its task is taken.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      mdl_count  = 5'd1;
      mdl_dual   = 1'b0;
      mdl_rr     = 1'b0;
      mdl_lcg    = DEFAULT_SEED;
      mdl_rr_idx = '0;
      pending_dispatch.delete();
    end else begin
      if (out_valid && !out_stall)
        check_result();
      if (cfg_write)
        apply_cfg(cfg_index, cfg_data);
      if (in_valid && !in_stall)
        route_task(task_tag);
    end
  end

  // Watchdog: a run that stops moving is a failure.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t watchdog: no transaction for %0d cycles", $time, IDLE_LIMIT);
      $display("== FAIL ==");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // mostly no gap, often a short one, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(99, 0);
    if (r < 60)
      return 0;
    else if (r < 92)
      return $urandom_range(3, 1);
    else
      return $urandom_range(40, 8);
  endfunction

  // Output back-pressure: random stall bursts, off in quiet stretches.
  always @(posedge clk) begin
    if (stall_left == 0 && !drain_quiet && $urandom_range(2, 0) == 0)
      stall_left = pick_gap();
    out_stall <= (stall_left != 0);
    if (stall_left != 0)
      stall_left--;
  end

  // ---------------------------------------------------------------------------
  // Drivers. Each task is entered right after a rising edge. send_task leaves
  // in_valid high after its transaction so back-to-back tasks never lower and
  // raise it in one step; drain_results or a gap before the next task drops it.
  // ---------------------------------------------------------------------------
  task automatic send_task(input logic [TAG_W-1:0] tag);
    int unsigned gap;
    gap = send_quiet ? 0 : pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    task_tag <= tag;
    do
      @(posedge clk);
    while (in_stall);
  endtask

  // stop sending and wait for every expected transaction, plus a little slack
  task automatic drain_results();
    in_valid <= 1'b0;
    do
      @(posedge clk);
    while (pending_dispatch.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_cfg(input cfg_reg_t idx, input logic [SEED_W-1:0] value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_mode(input logic [4:0] count, input logic dual, input logic rr);
    write_cfg(CFG_WORKER_COUNT, SEED_W'(count));
    write_cfg(CFG_DUAL_DISPATCH, SEED_W'(dual));
    write_cfg(CFG_ROUND_ROBIN, SEED_W'(rr));
  endtask

  // ---------------------------------------------------------------------------
  // Directed tests
  // ---------------------------------------------------------------------------

  // out of reset: one worker, random mode; tag extremes pass through
  task automatic test_reset_defaults();
    send_task(16'h0000);
    send_task(16'hFFFF);
    send_task(16'hA5A5);
    drain_results();
  endtask

  // one worker ignores dual mode: worker 0, single copy
  task automatic test_single_worker_dual();
    set_mode(5'd1, 1'b1, 1'b1);
    send_task(16'h1234);
    send_task(16'h5A5A);
    drain_results();
  endtask

  // dual with two workers always goes 0 then 1
  task automatic test_fixed_pair();
    set_mode(5'd2, 1'b1, 1'b0);
    send_task(16'h0F0F);
    send_task(16'hF0F0);
    drain_results();
  endtask

  // single round robin wraps at the count; dual round robin steps by two
  task automatic test_round_robin();
    set_mode(5'd3, 1'b0, 1'b1);
    send_task(16'h0001);
    send_task(16'h0002);
    send_task(16'h0003);
    send_task(16'h0004);
    drain_results();
    set_mode(5'd5, 1'b1, 1'b1);
    send_task(16'h0010);
    send_task(16'h0020);
    send_task(16'h0030);
    drain_results();
  endtask

  // random picks from seed extremes; three workers in dual mode can force redraws
  task automatic test_random_choice();
    write_cfg(CFG_RANDOM_SEED, '0);
    set_mode(5'd16, 1'b0, 1'b0);
    send_task(16'h8000);
    send_task(16'h7FFF);
    drain_results();
    write_cfg(CFG_RANDOM_SEED, '1);
    set_mode(5'd3, 1'b1, 1'b0);
    send_task(16'hC3C3);
    send_task(16'h3C3C);
    send_task(16'h9999);
    drain_results();
  endtask

  // count of zero acts as one; counts above the limit saturate
  task automatic test_count_limits();
    set_mode(5'd0, 1'b0, 1'b1);
    send_task(16'h0101);
    send_task(16'h0202);
    drain_results();
    set_mode(5'd31, 1'b0, 1'b1);
    send_task(16'h0303);
    send_task(16'h0404);
    drain_results();
    set_mode(5'd17, 1'b1, 1'b0);
    send_task(16'h0505);
    send_task(16'h0606);
    drain_results();
  endtask

  // ---------------------------------------------------------------------------
  // Random traffic in phases: new settings each phase (extremes included),
  // random tags, random gaps and stalls with quiet stretches, and an
  // occasional mid-phase pause until everything has come back.
  // ---------------------------------------------------------------------------
  task automatic test_random_traffic();
    int unsigned       sent;
    int unsigned       burst;
    int unsigned       pause_at;
    logic [4:0]        count;
    logic [SEED_W-1:0] seed;
    sent = 0;
    while (sent < RANDOM_TASKS) begin
      case ($urandom_range(9, 0))
        0:       count = 5'd0;
        1:       count = 5'd1;
        2:       count = 5'd31;
        3:       count = 5'($urandom_range(30, 17));
        4:       count = 5'd16;
        default: count = 5'($urandom_range(15, 2));
      endcase
      if ($urandom_range(2, 0) == 0) begin
        case ($urandom_range(5, 0))
          0:       seed = '0;
          1:       seed = '1;
          default: seed = {16'($urandom()), $urandom()};
        endcase
        write_cfg(CFG_RANDOM_SEED, seed);
      end
      set_mode(count, 1'($urandom_range(1, 0)), 1'($urandom_range(1, 0)));
      send_quiet  = ($urandom_range(4, 0) == 0);
      drain_quiet = ($urandom_range(4, 0) == 0);
      burst    = $urandom_range(80, 20);
      pause_at = $urandom_range(burst - 1, 1);
      for (int i = 0; i < burst; i++) begin
        if (i == pause_at && $urandom_range(2, 0) == 0)
          drain_results();
        send_task(16'($urandom()));
      end
      sent += burst;
      drain_results();
    end
    send_quiet  = 1'b0;
    drain_quiet = 1'b0;
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_single_worker_dual();
    test_fixed_pair();
    test_round_robin();
    test_random_choice();
    test_count_limits();
    test_random_traffic();

    drain_results();
    repeat (SETTLE) @(posedge clk);
    if (pending_dispatch.size() != 0)
      note_error($sformatf("%0d results never arrived", pending_dispatch.size()));

    if (error_count == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule

// File: filelist.f
rtl/twd_pkg.sv
rtl/twd_dp.sv
rtl/twd_ctrl.sv
rtl/task_worker_dispatch_core.sv
rtl/twd_checker.sv
bench/tb_task_worker_dispatch_core.sv
